>>> design/audio_playout_buffer_with_fades_defines.svh
// Assertion helpers for the playout buffer. Every check runs on clock and is
// switched off while reset is high.
`ifndef AUDIO_PLAYOUT_BUFFER_WITH_FADES_DEFINES_SVH
`define AUDIO_PLAYOUT_BUFFER_WITH_FADES_DEFINES_SVH

// Condition that holds at every edge
`define APBF_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequence in the same cycle
`define APBF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the next cycle
`define APBF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/apbf_pkg.sv
package apbf_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int CMD_W    = 2;
   localparam int FRAME_W  = 7;
   localparam int THR_W    = 12;
   localparam int CNT_W    = 32;
   localparam int QUEUED_W = 13;

   // Default sizing
   localparam int DEF_FIFO_DEPTH   = 4096;
   localparam int DEF_MAX_PERIOD   = 64;
   localparam int DEF_FADE_IN_LEN  = 64;
   localparam int DEF_FADE_OUT_MAX = 32;

   // Fade-in gain is (FADE_GAIN_OFFSET - r) / 2**FADE_SHIFT
   localparam int FADE_GAIN_OFFSET = 65;
   localparam int FADE_SHIFT       = 6;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PULL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Sequencer to fade-out unit
   typedef struct packed {
      logic                       start;
      logic                       step;
      logic signed [SAMPLE_W-1:0] seed;
      logic [FRAME_W-1:0]         len;
   } ramp_ctrl_type;

   // Fade-out unit to sequencer
   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] sample;
   } ramp_stat_type;

endpackage

>>> design/apbf_req_if.sv
interface apbf_req_if import apbf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       batch_end;
   logic [FRAME_W-1:0]         period_frames;

   modport source (output valid, cmd, sample_in, batch_end, period_frames, input ready);
   modport sink   (input valid, cmd, sample_in, batch_end, period_frames, output ready);
endinterface

>>> design/apbf_rsp_if.sv
interface apbf_rsp_if import apbf_pkg::*; #(
   parameter int QueuedW = QUEUED_W
);
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       last;
   logic                       accepted;
   logic                       underflow_now;
   logic [QueuedW-1:0]         queued;
   logic [CNT_W-1:0]           underflow_total;
   logic [CNT_W-1:0]           overflow_total;

   modport source (output valid, sample_out, last, accepted, underflow_now, queued,
                   underflow_total, overflow_total, input ready);
   modport sink   (input valid, sample_out, last, accepted, underflow_now, queued,
                   underflow_total, overflow_total, output ready);
endinterface

>>> design/apbf_ramp_unit.sv
// Fade-out ramp generator. On start it divides |seed| by len one quotient bit
// a cycle, then each step yields seed * k / len for k = len-1 down to 0,
// truncated toward zero, by subtracting the quotient and remainder once per
// frame. One subtractor serves both the divide and the ramp.
module apbf_ramp_unit import apbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ramp_ctrl_type ctrl,
   output ramp_stat_type stat
);

   localparam int DivCntW = $clog2(SAMPLE_W);
   localparam logic [DivCntW-1:0] DivLast = DivCntW'(SAMPLE_W - 1);

   logic                busy_ff, busy_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic                sign_ff, sign_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [FRAME_W-1:0]  rem_ff, rem_in;
   logic [FRAME_W-1:0]  len_ff, len_in;
   logic [SAMPLE_W-1:0] qm_ff, qm_in;
   logic [FRAME_W-1:0]  rm_ff, rm_in;

   logic [FRAME_W:0]    rem_sh;
   logic [FRAME_W:0]    sub_a, sub_b;
   logic [FRAME_W+1:0]  diff;
   logic                neg;
   logic [FRAME_W+1:0]  rm_fix;
   logic [SAMPLE_W-1:0] qm_next;
   logic [SAMPLE_W-1:0] mag;

   // Shared subtractor: divide trial while busy, remainder step otherwise
   assign rem_sh = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign sub_a  = busy_ff ? rem_sh : {1'b0, rm_ff};
   assign sub_b  = busy_ff ? {1'b0, len_ff} : {1'b0, rem_ff};
   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign neg    = diff[FRAME_W+1];

   // Ramp magnitude for the frame being stepped
   assign rm_fix  = diff + {2'b00, len_ff};
   assign qm_next = qm_ff - quo_ff - SAMPLE_W'(neg);
   assign mag     = ctrl.seed[SAMPLE_W-1] ? SAMPLE_W'(-ctrl.seed) : SAMPLE_W'(ctrl.seed);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sign_in = sign_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      qm_in   = qm_ff;
      rm_in   = rm_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sign_in = ctrl.seed[SAMPLE_W-1];
         quo_in  = mag;
         rem_in  = '0;
         len_in  = ctrl.len;
         qm_in   = mag;
         rm_in   = '0;
      end else if (busy_ff) begin
         // one restoring divide step
         rem_in = neg ? rem_sh[FRAME_W-1:0] : diff[FRAME_W-1:0];
         quo_in = {quo_ff[SAMPLE_W-2:0], ~neg};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivLast) begin
            busy_in = 1'b0;
         end
      end else if (ctrl.step) begin
         // advance the ramp by one frame, borrow from remainder
         rm_in = neg ? rm_fix[FRAME_W-1:0] : diff[FRAME_W-1:0];
         qm_in = qm_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sign_ff <= sign_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      len_ff  <= len_in;
      qm_ff   <= qm_in;
      rm_ff   <= rm_in;
   end

   assign stat.done   = ~busy_ff;
   assign stat.sample = sign_ff ? -$signed(qm_next) : $signed(qm_next);

endmodule

>>> design/audio_playout_buffer_with_fades.sv
// Mono playout buffer with fade-in after priming and fade-out on underrun.
// req_chan carries one command per beat: push a sample, pull a period of
// frames, or clear and stop. rsp_chan returns one beat per push, clear or
// unknown command, and period_frames beats per pull (saturated to MAX_PERIOD,
// none for a zero-length pull); last marks the final beat of a command.
// csr_we/csr_wdata write the prime threshold, to be done while idle.
// A push or clear is latched from its request beat, then executed into the
// output register. A pull first decides in the execute state, then reads
// each frame from the sample memory (registered read in the fetch state,
// then fade-in scaling into the output register), runs the fade-out divide
// when the pull runs short, and then emits each ramp or zero frame.
// A new request is taken only when the sequencer is idle, while the last
// beat of the previous command may still sit in the output register.
// A stalled rsp_chan freezes the sequencer at the next beat it must emit.
// Reset stops playback, empties the queue, zeroes both counters and sets the
// threshold to 256; the sample memory keeps its contents and needs no sweep.
`include "audio_playout_buffer_with_fades_defines.svh"
module audio_playout_buffer_with_fades import apbf_pkg::*; #(
   parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
   parameter int MAX_PERIOD   = DEF_MAX_PERIOD,
   parameter int FADE_IN_LEN  = DEF_FADE_IN_LEN,
   parameter int FADE_OUT_MAX = DEF_FADE_OUT_MAX
) (
   input  logic              clock,
   input  logic              reset,
   apbf_req_if.sink          req_chan,
   apbf_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [THR_W-1:0]  csr_wdata
);

   localparam int AW   = $clog2(FIFO_DEPTH);
   localparam int FW   = $clog2(FIFO_DEPTH + 1);
   localparam int CmpW = (FW > THR_W) ? FW + 1 : THR_W + 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXEC  = 7'b0000010,
      ST_FETCH = 7'b0000100,
      ST_CALC  = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_RAMP  = 7'b0100000,
      ST_FILL  = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CMD_W-1:0]           cmd_ff, cmd_in;
   logic [SAMPLE_W-1:0]        smp_ff, smp_in;
   logic                       bend_ff, bend_in;
   logic [FRAME_W-1:0]         n_ff, n_in;

   logic [AW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       running_ff, running_in;
   logic                       primed_ff, primed_in;
   logic [FRAME_W-1:0]         fade_ff, fade_in;
   logic signed [SAMPLE_W-1:0] last_val_ff, last_val_in;
   logic                       bdrop_ff, bdrop_in;
   logic [CNT_W-1:0]           ufc_ff, ufc_in;
   logic [CNT_W-1:0]           ofc_ff, ofc_in;
   logic [THR_W-1:0]           thr_ff;

   logic [FRAME_W-1:0]         pop_left_ff, pop_left_in;
   logic [FRAME_W-1:0]         ramp_left_ff, ramp_left_in;
   logic [FRAME_W-1:0]         frames_left_ff, frames_left_in;
   logic                       short_ff, short_in;

   logic [SAMPLE_W-1:0]        store_mem [FIFO_DEPTH];
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       mem_we;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_last_ff;
   logic                       rsp_acc_ff;
   logic                       rsp_short_ff;
   logic [FW-1:0]              rsp_queued_ff;
   logic [CNT_W-1:0]           rsp_uf_ff;
   logic [CNT_W-1:0]           rsp_of_ff;

   logic                       emit;
   logic signed [SAMPLE_W-1:0] emit_sample;
   logic                       emit_last;
   logic                       emit_acc;
   logic                       emit_short;
   logic                       out_free;
   logic                       req_beat;

   ramp_ctrl_type              ramp_ctrl;
   ramp_stat_type              ramp_stat;

   // pull decision terms
   logic                       full;
   logic [FW-1:0]              fill_push;
   logic                       bdrop_now;
   logic                       play;
   logic                       arm;
   logic [FRAME_W-1:0]         rd_cnt;
   logic [FRAME_W-1:0]         missing;
   logic [FRAME_W-1:0]         fade_len;
   logic                       run_short;
   logic signed [SAMPLE_W-1:0] seed_exec;

   // fade-in scaling of a popped sample
   logic [FRAME_W-1:0]         gain;
   logic signed [SAMPLE_W+8-1:0] prod;
   logic signed [SAMPLE_W-1:0] popped;

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat = req_chan.valid & req_chan.ready;

   assign full      = (fill_ff == FW'(FIFO_DEPTH));
   assign fill_push = full ? fill_ff : fill_ff + 1'b1;
   assign bdrop_now = bdrop_ff | full;

   assign play      = running_ff & (primed_ff | (CmpW'(fill_ff) >= CmpW'(thr_ff)));
   assign arm       = play & ~primed_ff;
   assign rd_cnt    = ~play ? '0 :
                      (CmpW'(fill_ff) < CmpW'(n_ff)) ? FRAME_W'(fill_ff) : n_ff;
   assign missing   = n_ff - rd_cnt;
   assign run_short = play & (rd_cnt != n_ff);
   assign fade_len  = (missing < FRAME_W'(FADE_OUT_MAX)) ? missing : FRAME_W'(FADE_OUT_MAX);
   assign seed_exec = arm ? '0 : last_val_ff;

   assign gain   = FRAME_W'(FADE_GAIN_OFFSET - int'(fade_ff));
   assign prod   = $signed(rd_data_ff) * $signed({1'b0, gain});
   assign popped = (fade_ff != '0) ? prod[FADE_SHIFT +: SAMPLE_W] : $signed(rd_data_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      smp_in         = smp_ff;
      bend_in        = bend_ff;
      n_in           = n_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      fill_in        = fill_ff;
      running_in     = running_ff;
      primed_in      = primed_ff;
      fade_in        = fade_ff;
      last_val_in    = last_val_ff;
      bdrop_in       = bdrop_ff;
      ufc_in         = ufc_ff;
      ofc_in         = ofc_ff;
      pop_left_in    = pop_left_ff;
      ramp_left_in   = ramp_left_ff;
      frames_left_in = frames_left_ff;
      short_in       = short_ff;
      mem_we         = 1'b0;
      emit           = 1'b0;
      emit_sample    = '0;
      emit_last      = (frames_left_ff == FRAME_W'(1));
      emit_acc       = 1'b0;
      emit_short     = short_ff;
      ramp_ctrl      = '0;

      case (state_ff)
         ST_IDLE: begin
            // latch the request beat, saturate the period
            if (req_beat) begin
               cmd_in  = req_chan.cmd;
               smp_in  = req_chan.sample_in;
               bend_in = req_chan.batch_end;
               n_in    = (req_chan.period_frames > FRAME_W'(MAX_PERIOD)) ?
                         FRAME_W'(MAX_PERIOD) : req_chan.period_frames;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_PUSH: begin
                  if (out_free) begin
                     mem_we  = ~full;
                     fill_in = fill_push;
                     if (!full) begin
                        wr_ptr_in = (wr_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                     end
                     bdrop_in = bdrop_now;
                     if (bend_ff) begin
                        if (bdrop_now) begin
                           ofc_in   = ofc_ff + 1'b1;
                           bdrop_in = 1'b0;
                        end
                        if (!running_ff && (CmpW'(fill_push) >= CmpW'(thr_ff))) begin
                           running_in  = 1'b1;
                           primed_in   = 1'b1;
                           fade_in     = FRAME_W'(FADE_IN_LEN);
                           last_val_in = '0;
                        end
                     end
                     emit       = 1'b1;
                     emit_last  = 1'b1;
                     emit_acc   = ~full;
                     emit_short = 1'b0;
                     state_in   = ST_IDLE;
                  end
               end
               CMD_PULL: begin
                  if (arm) begin
                     primed_in   = 1'b1;
                     fade_in     = FRAME_W'(FADE_IN_LEN);
                     last_val_in = '0;
                  end
                  fill_in        = fill_ff - FW'(rd_cnt);
                  pop_left_in    = rd_cnt;
                  ramp_left_in   = run_short ? fade_len : '0;
                  frames_left_in = n_ff;
                  short_in       = run_short;
                  if (run_short) begin
                     primed_in = 1'b0;
                     ufc_in    = ufc_ff + 1'b1;
                  end
                  if (n_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (rd_cnt != '0) begin
                     state_in = ST_FETCH;
                  end else if (run_short) begin
                     ramp_ctrl.start = 1'b1;
                     ramp_ctrl.seed  = seed_exec;
                     ramp_ctrl.len   = fade_len;
                     fade_in         = '0;
                     last_val_in     = '0;
                     state_in        = ST_DIV;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
               CMD_CLEAR: begin
                  if (out_free) begin
                     running_in  = 1'b0;
                     primed_in   = 1'b0;
                     fade_in     = '0;
                     last_val_in = '0;
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     fill_in     = '0;
                     emit        = 1'b1;
                     emit_last   = 1'b1;
                     emit_short  = 1'b0;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  // unknown command: status beat only
                  if (out_free) begin
                     emit       = 1'b1;
                     emit_last  = 1'b1;
                     emit_short = 1'b0;
                     state_in   = ST_IDLE;
                  end
               end
            endcase
         end
         ST_FETCH: begin
            // memory read happens at this edge; advance the read pointer
            rd_ptr_in = (rd_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_sample    = popped;
               last_val_in    = popped;
               if (fade_ff != '0) begin
                  fade_in = fade_ff - 1'b1;
               end
               pop_left_in    = pop_left_ff - 1'b1;
               frames_left_in = frames_left_ff - 1'b1;
               if (pop_left_ff != FRAME_W'(1)) begin
                  state_in = ST_FETCH;
               end else if (ramp_left_ff != '0) begin
                  ramp_ctrl.start = 1'b1;
                  ramp_ctrl.seed  = popped;
                  ramp_ctrl.len   = ramp_left_ff;
                  fade_in         = '0;
                  last_val_in     = '0;
                  state_in        = ST_DIV;
               end else if (frames_left_ff != FRAME_W'(1)) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            // wait for the ramp divide
            if (ramp_stat.done) begin
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            if (out_free) begin
               ramp_ctrl.step = 1'b1;
               emit           = 1'b1;
               emit_sample    = ramp_stat.sample;
               ramp_left_in   = ramp_left_ff - 1'b1;
               frames_left_in = frames_left_ff - 1'b1;
               if (ramp_left_ff != FRAME_W'(1)) begin
                  state_in = ST_RAMP;
               end else if (frames_left_ff != FRAME_W'(1)) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            // pad with silence
            if (out_free) begin
               emit           = 1'b1;
               frames_left_in = frames_left_ff - 1'b1;
               if (frames_left_ff == FRAME_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_chan.ready);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         fill_ff        <= '0;
         running_ff     <= 1'b0;
         primed_ff      <= 1'b0;
         fade_ff        <= '0;
         last_val_ff    <= '0;
         bdrop_ff       <= 1'b0;
         ufc_ff         <= '0;
         ofc_ff         <= '0;
         thr_ff         <= THR_RESET;
         pop_left_ff    <= '0;
         ramp_left_ff   <= '0;
         frames_left_ff <= '0;
         short_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         fill_ff        <= fill_in;
         running_ff     <= running_in;
         primed_ff      <= primed_in;
         fade_ff        <= fade_in;
         last_val_ff    <= last_val_in;
         bdrop_ff       <= bdrop_in;
         ufc_ff         <= ufc_in;
         ofc_ff         <= ofc_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         pop_left_ff    <= pop_left_in;
         ramp_left_ff   <= ramp_left_in;
         frames_left_ff <= frames_left_in;
         short_ff       <= short_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Request payload hold
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      smp_ff  <= smp_in;
      bend_ff <= bend_in;
      n_ff    <= n_in;
   end

   // Sample memory: write on push, registered read on fetch
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ptr_ff] <= smp_ff;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff <= store_mem[rd_ptr_ff];
      end
   end

   // Output beat register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sample_ff <= emit_sample;
         rsp_last_ff   <= emit_last;
         rsp_acc_ff    <= emit_acc;
         rsp_short_ff  <= emit_short;
         rsp_queued_ff <= fill_in;
         rsp_uf_ff     <= ufc_in;
         rsp_of_ff     <= ofc_in;
      end
   end

   apbf_ramp_unit u_ramp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ramp_ctrl),
      .stat  (ramp_stat)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sample_out      = rsp_sample_ff;
   assign rsp_chan.last            = rsp_last_ff;
   assign rsp_chan.accepted        = rsp_acc_ff;
   assign rsp_chan.underflow_now   = rsp_short_ff;
   assign rsp_chan.queued          = rsp_queued_ff;
   assign rsp_chan.underflow_total = rsp_uf_ff;
   assign rsp_chan.overflow_total  = rsp_of_ff;

   `APBF_ASSERT_HOLDS(a_fill_bound, fill_ff <= FW'(FIFO_DEPTH), "fill count above depth")
   `APBF_ASSERT_IMPLIES(a_ramp_ready, state_ff == ST_RAMP, ramp_stat.done, "ramp stepped while dividing")
   `APBF_ASSERT_IMPLIES(a_frames_left, (state_ff == ST_FETCH) || (state_ff == ST_CALC) || (state_ff == ST_RAMP) || (state_ff == ST_FILL), frames_left_ff != '0, "pull frame with no frames left")
   `APBF_ASSERT_NEXT(a_req_exec, req_beat, state_ff == ST_EXEC, "request beat not executed")

endmodule

>>> tb/tb.sv
module tb;
   import apbf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam int               THR_MAX       = (1 << THR_W) - 1;
   localparam int               SETTLE_CYCLES = 250;

   // One request beat
   typedef struct {
      logic [CMD_W-1:0]           cmd;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       batch_end;
      logic [FRAME_W-1:0]         frames;
   } playout_cmd_type;

   // One response beat
   typedef struct {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       last;
      logic                       accepted;
      logic                       underflow_now;
      logic [QUEUED_W-1:0]        queued;
      logic [CNT_W-1:0]           underflow_total;
      logic [CNT_W-1:0]           overflow_total;
   } playout_frame_type;

   // Mirror of the playout buffer: predicts the frames each command produces
   class playout_scoreboard;
      logic signed [SAMPLE_W-1:0] ring [DEF_FIFO_DEPTH];
      int                         head;
      int                         tail;
      int                         fill;
      bit                         running;
      bit                         primed;
      bit                         batch_lost;
      int                         fade_left;
      int                         hold_value;
      bit [CNT_W-1:0]             short_pulls;
      bit [CNT_W-1:0]             lossy_batches;
      int                         threshold;
      playout_frame_type          expected_frames [$];
      int                         errors;

      function new();
         threshold = THR_RESET;
      endfunction

      function void arm_fade_in();
         primed     = 1'b1;
         fade_left  = DEF_FADE_IN_LEN;
         hold_value = 0;
      endfunction

      function void note_request(playout_cmd_type c);
         int                frame_val [DEF_MAX_PERIOD];
         int                count;
         int                n;
         int                rd;
         int                span;
         int                s;
         bit                stored;
         bit                ran_short;
         playout_frame_type f;
         count     = 1;
         stored    = 1'b0;
         ran_short = 1'b0;
         foreach (frame_val[i]) frame_val[i] = 0;
         case (c.cmd)
            CMD_PUSH: begin
               // store unless full, then settle the batch at its end
               if (fill < DEF_FIFO_DEPTH) begin
                  ring[tail] = c.sample;
                  tail       = (tail + 1) % DEF_FIFO_DEPTH;
                  fill++;
                  stored = 1'b1;
               end else begin
                  batch_lost = 1'b1;
               end
               if (c.batch_end) begin
                  if (batch_lost) begin
                     lossy_batches++;
                     batch_lost = 1'b0;
                  end
                  if (!running && fill >= threshold) begin
                     running = 1'b1;
                     arm_fade_in();
                  end
               end
            end
            CMD_PULL: begin
               n     = (c.frames > DEF_MAX_PERIOD) ? DEF_MAX_PERIOD : c.frames;
               count = n;
               if (running && (primed || fill >= threshold)) begin
                  if (!primed) arm_fade_in();
                  rd = (fill < n) ? fill : n;
                  // pop with the fade-in gain while it lasts
                  for (int i = 0; i < rd; i++) begin
                     s    = ring[head];
                     head = (head + 1) % DEF_FIFO_DEPTH;
                     fill--;
                     if (fade_left > 0) begin
                        s = (s * (FADE_GAIN_OFFSET - fade_left)) >>> FADE_SHIFT;
                        fade_left--;
                     end
                     frame_val[i] = s;
                     hold_value   = s;
                  end
                  // ramp down from the last frame on a shortfall, zeros after
                  if (rd < n) begin
                     span = (n - rd < DEF_FADE_OUT_MAX) ? n - rd : DEF_FADE_OUT_MAX;
                     for (int i = 0; i < span; i++)
                        frame_val[rd + i] = (hold_value * (span - 1 - i)) / span;
                     primed     = 1'b0;
                     fade_left  = 0;
                     hold_value = 0;
                     short_pulls++;
                     ran_short = 1'b1;
                  end
               end
            end
            CMD_CLEAR: begin
               running    = 1'b0;
               primed     = 1'b0;
               fade_left  = 0;
               hold_value = 0;
               head       = 0;
               tail       = 0;
               fill       = 0;
            end
            default: ;
         endcase
         for (int k = 0; k < count; k++) begin
            f.sample_out      = SAMPLE_W'(frame_val[k]);
            f.last            = (k == count - 1);
            f.accepted        = stored;
            f.underflow_now   = ran_short;
            f.queued          = QUEUED_W'(fill);
            f.underflow_total = short_pulls;
            f.overflow_total  = lossy_batches;
            expected_frames.push_back(f);
         end
      endfunction

      function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_frame(playout_frame_type got);
         playout_frame_type want;
         if (expected_frames.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual sample_out %h last %b",
                     $time, got.sample_out, got.last);
            return;
         end
         want = expected_frames.pop_front();
         compare_field("sample_out", want.sample_out, got.sample_out);
         compare_field("last", want.last, got.last);
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("underflow_now", want.underflow_now, got.underflow_now);
         compare_field("queued", want.queued, got.queued);
         compare_field("underflow_total", want.underflow_total, got.underflow_total);
         compare_field("overflow_total", want.overflow_total, got.overflow_total);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [THR_W-1:0]    csr_wdata;
   bit                  fast_mode;
   playout_scoreboard   sb;

   apbf_req_if req_chan ();
   apbf_rsp_if rsp_chan ();

   audio_playout_buffer_with_fades i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      playout_cmd_type   c;
      playout_frame_type r;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            c.cmd       = req_chan.cmd;
            c.sample    = req_chan.sample_in;
            c.batch_end = req_chan.batch_end;
            c.frames    = req_chan.period_frames;
            sb.note_request(c);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            r.sample_out      = rsp_chan.sample_out;
            r.last            = rsp_chan.last;
            r.accepted        = rsp_chan.accepted;
            r.underflow_now   = rsp_chan.underflow_now;
            r.queued          = rsp_chan.queued;
            r.underflow_total = rsp_chan.underflow_total;
            r.overflow_total  = rsp_chan.overflow_total;
            sb.check_frame(r);
         end
      end
   end

   // Stall the response side for a random number of cycles per beat
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = fast_mode ? 0 : $urandom_range(9);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // Drive one request beat; valid stays high afterwards until the next call or wait_drained
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [SAMPLE_W-1:0] sample,
                               input logic batch_end,
                               input logic [FRAME_W-1:0] frames);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(9);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.cmd           = cmd;
      req_chan.sample_in     = sample;
      req_chan.batch_end     = batch_end;
      req_chan.period_frames = frames;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] sample, input logic batch_end);
      send_command(CMD_PUSH, sample, batch_end, FRAME_W'($urandom));
   endtask

   task automatic pull_frames(input int n);
      send_command(CMD_PULL, SAMPLE_W'($urandom), 1'($urandom), FRAME_W'(n));
   endtask

   // Hold off requests until every predicted beat has come back
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (sb.expected_frames.size() != 0) @(negedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = THR_W'(value);
      @(negedge clock);
      csr_we       = 1'b0;
      sb.threshold = value;
   endtask

   // A batch of pushes; a broken batch has batch_end at random
   task automatic push_batch(input int len, input bit broken);
      logic signed [SAMPLE_W-1:0] s;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(7))
            0:       s = 16'sh7FFF;
            1:       s = 16'sh8000;
            default: s = SAMPLE_W'($urandom);
         endcase
         push_sample(s, broken ? 1'($urandom) : (i == len - 1));
      end
   endtask

   task automatic random_phase(input int items);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(39) == 0) fast_mode = ~fast_mode;
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = $urandom_range(1, 24);
            push_batch(len, $urandom_range(9) == 0);
            sent += len;
         end else if (pick < 85) begin
            case ($urandom_range(9))
               0:       pull_frames(0);
               1:       pull_frames($urandom_range(DEF_MAX_PERIOD + 1, 127));
               default: pull_frames($urandom_range(1, DEF_MAX_PERIOD));
            endcase
            sent++;
         end else if (pick < 89) begin
            send_command(CMD_CLEAR, SAMPLE_W'($urandom), 1'($urandom), FRAME_W'($urandom));
            sent++;
         end else if (pick < 94) begin
            send_command(CMD_RESERVED, SAMPLE_W'($urandom), 1'($urandom), FRAME_W'($urandom));
         end else begin
            wait_drained();
         end
      end
      fast_mode = 1'b0;
   endtask

   initial begin
      sb                     = new();
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      fast_mode              = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.cmd           = CMD_PUSH;
      req_chan.sample_in     = '0;
      req_chan.batch_end     = 1'b0;
      req_chan.period_frames = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: stopped pulls, start on batch end, fade-in, shortfall,
      // unprimed pull, re-prime by an empty pull, saturation, clear
      write_threshold(4);
      pull_frames(5);
      send_command(CMD_RESERVED, 16'sh7FFF, 1'b1, 7'h7F);
      pull_frames(0);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh0000, 1'b0);
      push_sample(16'shFFFF, 1'b1);
      push_sample(16'sd12345, 1'b0);
      push_sample(-16'sd20000, 1'b1);
      pull_frames(1);
      pull_frames(3);
      pull_frames(100);
      pull_frames(7);
      push_sample(16'sd1000, 1'b0);
      push_sample(16'sd2000, 1'b0);
      push_sample(-16'sd3000, 1'b0);
      push_sample(16'sd4000, 1'b1);
      pull_frames(0);
      pull_frames(127);
      send_command(CMD_CLEAR, 16'sh0000, 1'b0, 7'd0);
      push_sample(16'sd500, 1'b1);
      pull_frames(DEF_MAX_PERIOD);

      // Random traffic under several thresholds, zero among them
      write_threshold(0);
      random_phase(70);
      write_threshold(1);
      random_phase(70);
      write_threshold($urandom_range(2, 48));
      random_phase(70);

      // Queue below a threshold that is never reached, then pull while stopped
      write_threshold(THR_MAX);
      send_command(CMD_CLEAR, 16'sh0000, 1'b0, 7'd0);
      push_batch(8, 1'b0);
      pull_frames(DEF_MAX_PERIOD);
      pull_frames(DEF_MAX_PERIOD);

      write_threshold(2048);
      random_phase(40);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/apbf_pkg.sv
design/apbf_req_if.sv
design/apbf_rsp_if.sv
design/apbf_ramp_unit.sv
design/audio_playout_buffer_with_fades.sv
tb/tb.sv
